FILE: hdl/window_peak_segment_detector_macros.svh
`ifndef WINDOW_PEAK_SEGMENT_DETECTOR_MACROS_SVH
`define WINDOW_PEAK_SEGMENT_DETECTOR_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define WPSD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define WPSD_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/wpsd_pkg.sv
`timescale 1ns / 1ps

package wpsd_pkg;

    // block dimensions
    localparam int WINDOW       = 1200;
    localparam int MAX_SEGMENTS = 49;
    localparam int INDEX_BITS   = 20;

    // field widths
    localparam int SAMPLE_W = 24;
    localparam int MAG_W    = 24;
    localparam int THR_W    = 23;
    localparam int CNT_W    = INDEX_BITS + 1;
    localparam int SEG_W    = $clog2(MAX_SEGMENTS + 1);

    // ring addressing
    localparam int ADDR_W = $clog2(WINDOW);
    localparam int ISS_W  = $clog2(WINDOW + 1);

    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(15000);
    localparam logic [CNT_W-1:0]  CNT_WINDOW = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0]  CNT_LIMIT  = CNT_W'(1) << INDEX_BITS;
    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(WINDOW - 1);
    localparam logic [ADDR_W-1:0] CENTRE_OFF = ADDR_W'(WINDOW / 2);
    localparam logic [ISS_W-1:0]  ISS_WINDOW = ISS_W'(WINDOW);
    localparam logic [SEG_W-1:0]  SEG_MAX    = SEG_W'(MAX_SEGMENTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SEG_OUT,
        ST_SUM_OUT
    } wpsd_state_t;

    // control from the sequencer to the shared compare unit
    typedef struct packed {
        logic              clear;
        logic              valid;
        logic [ADDR_W-1:0] offset;
    } wpsd_peak_ctrl_t;

endpackage

FILE: hdl/wpsd_ram.sv
`timescale 1ns / 1ps

module wpsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1200
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/wpsd_peak_unit.sv
`timescale 1ns / 1ps

module wpsd_peak_unit
    import wpsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  wpsd_peak_ctrl_t       ctrl,
    input  logic [MAG_W-1:0]      mag,
    output logic [MAG_W-1:0]      best,
    output logic [ADDR_W-1:0]     best_off
);

    logic              any_reg, any_next;
    logic [MAG_W-1:0]  best_reg, best_next;
    logic [ADDR_W-1:0] off_reg, off_next;

    // shared compare: keep the first maximum seen in the sweep
    always_comb
    begin
        any_next  = any_reg;
        best_next = best_reg;
        off_next  = off_reg;
        if (ctrl.clear)
        begin
            any_next = 1'b0;
        end
        else if (ctrl.valid && (!any_reg || (mag > best_reg)))
        begin
            any_next  = 1'b1;
            best_next = mag;
            off_next  = ctrl.offset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg <= 1'b0;
        end
        else
        begin
            any_reg <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        off_reg  <= off_next;
    end

    assign best     = best_reg;
    assign best_off = off_reg;

endmodule

FILE: hdl/window_peak_segment_detector.sv
// Window peak segment detector.
// Input channel: sample (signed 24 bit) and record_end, qualified by in_valid;
// a transfer happens on a clock edge with in_valid high and in_stall low.
// Output channel: one result per transfer on out_valid / out_stall. A segment
// result carries segment_start, segment_end and segment_number; the summary
// result (record_done = 1) carries segment_count and dropped_any. last_of_run
// marks the final result caused by one input sample.
// Configuration: cfg_write loads cfg_data into the peak threshold (reset
// 15000); write only while the block is idle.
// Operation: one sample is worked on at a time. Before the window is full a
// sample is only stored (and the summary offered on record end). Once the
// window is full, each sample within the index space sweeps all 1200 ring
// entries through the single RAM read port and one shared comparator, and
// the window is then tested; a segment result follows the sweep.
// If the receiver stalls, the result is held and no new sample is taken.
// Reset (asynchronous, active low) clears the counters and segment state and
// restores the threshold to 15000; ring contents need no clearing since a
// window is only tested once fully rewritten in the current record.
`timescale 1ns / 1ps

module window_peak_segment_detector
    import wpsd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [THR_W-1:0]           cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       record_end,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [INDEX_BITS-1:0]      segment_start,
    output logic [CNT_W-1:0]           segment_end,
    output logic [SEG_W-1:0]           segment_number,
    output logic                       record_done,
    output logic [SEG_W-1:0]           segment_count,
    output logic                       dropped_any,
    output logic                       last_of_run
);

    wpsd_state_t state_reg, state_next;

    logic [THR_W-1:0]      thr_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      prev_end_reg, prev_end_next;
    logic [SEG_W-1:0]      found_reg, found_next;
    logic                  overflow_reg, overflow_next;
    logic                  end_reg, end_next;
    logic [ADDR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]     rd_addr_reg, rd_addr_next;
    logic [ISS_W-1:0]      issue_reg, issue_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [ADDR_W-1:0]     cmp_off_reg, cmp_off_next;
    logic [INDEX_BITS-1:0] seg_start_reg, seg_start_next;
    logic [CNT_W-1:0]      seg_end_reg, seg_end_next;
    logic [SEG_W-1:0]      seg_num_reg, seg_num_next;
    logic                  seg_last_reg, seg_last_next;

    logic                  in_xfer, out_xfer;
    logic                  ram_we, ram_re;
    logic [MAG_W-1:0]      mag, ram_rdata, best;
    logic [ADDR_W-1:0]     best_off, wr_ptr_inc;
    logic [CNT_W-1:0]      window_start;
    logic                  qualifies;
    wpsd_peak_ctrl_t       peak_ctrl;

    // input is taken only in idle
    assign in_stall = (state_reg != ST_IDLE);

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    // magnitude of the sample; the most negative value maps to 2^23
    assign mag = sample[SAMPLE_W-1] ? MAG_W'(-sample) : MAG_W'(sample);

    assign wr_ptr_inc   = (wr_ptr_reg == ADDR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign window_start = count_reg - CNT_WINDOW;
    assign qualifies    = (best_off == CENTRE_OFF) && (best > {1'b0, thr_reg})
                          && (window_start >= prev_end_reg);

    assign ram_we = (state_reg == ST_IDLE) && in_xfer && (count_reg < CNT_LIMIT);
    assign ram_re = (state_reg == ST_SCAN) && (issue_reg < ISS_WINDOW);

    // magnitude ring
    wpsd_ram #(
        .WIDTH (MAG_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (mag),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // shared compare unit
    assign peak_ctrl.clear  = ram_we;
    assign peak_ctrl.valid  = cmp_valid_reg;
    assign peak_ctrl.offset = cmp_off_reg;

    wpsd_peak_unit u_peak (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (peak_ctrl),
        .mag      (ram_rdata),
        .best     (best),
        .best_off (best_off)
    );

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        prev_end_next  = prev_end_reg;
        found_next     = found_reg;
        overflow_next  = overflow_reg;
        end_next       = end_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_addr_next   = rd_addr_reg;
        issue_next     = issue_reg;
        cmp_valid_next = ram_re;
        cmp_off_next   = issue_reg[ADDR_W-1:0];
        seg_start_next = seg_start_reg;
        seg_end_next   = seg_end_reg;
        seg_num_next   = seg_num_reg;
        seg_last_next  = seg_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    end_next = record_end;
                    if (count_reg < CNT_LIMIT)
                    begin
                        count_next  = count_reg + 1'b1;
                        wr_ptr_next = wr_ptr_inc;
                    end
                    if ((count_reg < CNT_LIMIT) && (count_reg + 1'b1 >= CNT_WINDOW))
                    begin
                        rd_addr_next = wr_ptr_inc;
                        issue_next   = '0;
                        state_next   = ST_SCAN;
                    end
                    else if (record_end)
                    begin
                        state_next = ST_SUM_OUT;
                    end
                end
            end

            ST_SCAN:
            begin
                if (ram_re)
                begin
                    issue_next   = issue_reg + 1'b1;
                    rd_addr_next = (rd_addr_reg == ADDR_LAST) ? '0 : rd_addr_reg + 1'b1;
                end
                if (cmp_valid_reg && (cmp_off_reg == ADDR_LAST))
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (qualifies && (found_reg < SEG_MAX))
                begin
                    seg_start_next = window_start[INDEX_BITS-1:0];
                    seg_end_next   = count_reg;
                    seg_num_next   = found_reg;
                    seg_last_next  = !end_reg;
                    prev_end_next  = count_reg;
                    found_next     = found_reg + 1'b1;
                    state_next     = ST_SEG_OUT;
                end
                else
                begin
                    if (qualifies)
                    begin
                        overflow_next = 1'b1;
                    end
                    state_next = end_reg ? ST_SUM_OUT : ST_IDLE;
                end
            end

            ST_SEG_OUT:
            begin
                if (out_xfer)
                begin
                    state_next = end_reg ? ST_SUM_OUT : ST_IDLE;
                end
            end

            ST_SUM_OUT:
            begin
                if (out_xfer)
                begin
                    count_next    = '0;
                    prev_end_next = '0;
                    found_next    = '0;
                    overflow_next = 1'b0;
                    wr_ptr_next   = '0;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= THR_RESET;
            count_reg     <= '0;
            prev_end_reg  <= '0;
            found_reg     <= '0;
            overflow_reg  <= 1'b0;
            end_reg       <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_addr_reg   <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            prev_end_reg  <= prev_end_next;
            found_reg     <= found_next;
            overflow_reg  <= overflow_next;
            end_reg       <= end_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_addr_reg   <= rd_addr_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            if (cfg_write)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    // segment result payload
    always_ff @(posedge clk)
    begin
        cmp_off_reg   <= cmp_off_next;
        seg_start_reg <= seg_start_next;
        seg_end_reg   <= seg_end_next;
        seg_num_reg   <= seg_num_next;
        seg_last_reg  <= seg_last_next;
    end

    // result fields, held while the state waits for the transfer
    always_comb
    begin
        out_valid      = (state_reg == ST_SEG_OUT) || (state_reg == ST_SUM_OUT);
        record_done    = (state_reg == ST_SUM_OUT);
        segment_start  = record_done ? '0 : seg_start_reg;
        segment_end    = record_done ? '0 : seg_end_reg;
        segment_number = record_done ? '0 : seg_num_reg;
        segment_count  = record_done ? found_reg : '0;
        dropped_any    = record_done ? overflow_reg : 1'b0;
        last_of_run    = record_done ? 1'b1 : seg_last_reg;
    end

    `include "window_peak_segment_detector_macros.svh"

    `WPSD_ASSERT_ALWAYS(a_found_cap, found_reg <= SEG_MAX, "segment count above cap")
    `WPSD_ASSERT_ALWAYS(a_count_limit, count_reg <= CNT_LIMIT, "sample count past index space")
    `WPSD_ASSERT_ALWAYS(a_one_item, !out_valid || in_stall, "input taken while result pending")
    `WPSD_ASSERT_NEXT(a_cmp_in_scan, cmp_valid_reg && (cmp_off_reg != ADDR_LAST), state_reg == ST_SCAN, "compare data outside sweep")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import wpsd_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int SETTLE         = WINDOW + 100;
    localparam int CYCLE_LIMIT    = 8_000_000;
    localparam int WINDOWS_PER_PH = 120;
    localparam int SAMPLE_MAX     = (1 << (SAMPLE_W - 1)) - 1;
    localparam int MAG_MOST       = 1 << (SAMPLE_W - 1);
    localparam logic [MAG_W-1:0] MOST_NEG_MAG = MAG_W'(MAG_MOST);

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } sample_item_t;

    typedef struct {
        logic [INDEX_BITS-1:0] start_idx;
        logic [CNT_W-1:0]      end_idx;
        logic [SEG_W-1:0]      seg_no;
        logic                  done;
        logic [SEG_W-1:0]      seg_cnt;
        logic                  dropped;
        logic                  last;
    } detection_t;

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       cfg_write  = 1'b0;
    logic [THR_W-1:0]           cfg_data   = '0;
    logic                       in_valid   = 1'b0;
    logic signed [SAMPLE_W-1:0] sample     = '0;
    logic                       record_end = 1'b0;
    logic                       out_stall  = 1'b0;

    logic                  in_stall;
    logic                  out_valid;
    logic [INDEX_BITS-1:0] segment_start;
    logic [CNT_W-1:0]      segment_end;
    logic [SEG_W-1:0]      segment_number;
    logic                  record_done;
    logic [SEG_W-1:0]      segment_count;
    logic                  dropped_any;
    logic                  last_of_run;

    // stimulus and expected detections
    sample_item_t               samples_to_send[$];
    logic signed [SAMPLE_W-1:0] record_buf[$];
    detection_t                 detections_due[$];
    detection_t                 head;

    // shadow of the detector state
    logic [MAG_W-1:0] mag_hist [WINDOW];
    int               n_seen    = 0;
    int               last_end  = 0;
    int               seg_total = 0;
    bit               seg_over  = 1'b0;
    logic [THR_W-1:0] thr_now   = THR_RESET;

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    bit          sample_taken  = 1'b0;
    int          mismatches    = 0;
    int unsigned cycles        = 0;

    window_peak_segment_detector i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .record_end     (record_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .segment_start  (segment_start),
        .segment_end    (segment_end),
        .segment_number (segment_number),
        .record_done    (record_done),
        .segment_count  (segment_count),
        .dropped_any    (dropped_any),
        .last_of_run    (last_of_run)
    );

    always #CLK_HALF clk = ~clk;

    // signed sample with the given magnitude; the most negative value has no sign choice
    function automatic logic signed [SAMPLE_W-1:0] with_sign(logic [MAG_W-1:0] m, bit neg);
        if (m == MOST_NEG_MAG)
        begin
            return SAMPLE_W'(m);
        end
        return neg ? SAMPLE_W'(-int'(m)) : SAMPLE_W'(int'(m));
    endfunction

    function automatic logic [MAG_W-1:0] magnitude_of(logic signed [SAMPLE_W-1:0] s);
        return MAG_W'(s < 0 ? -int'(s) : int'(s));
    endfunction

    // store the magnitude, test the window ending on this sample, close the record on its end flag
    task automatic predict_detections(logic signed [SAMPLE_W-1:0] s, logic rend);
        detection_t       d;
        int               base;
        int               best_at;
        int               i;
        logic [MAG_W-1:0] best;
        logic [MAG_W-1:0] m;
        if (n_seen < (1 << INDEX_BITS))
        begin
            mag_hist[n_seen % WINDOW] = magnitude_of(s);
            n_seen++;
            if (n_seen >= WINDOW)
            begin
                base    = n_seen - WINDOW;
                best    = mag_hist[base % WINDOW];
                best_at = base;
                for (i = base + 1; i < base + WINDOW; i++)
                begin
                    m = mag_hist[i % WINDOW];
                    if (m > best)
                    begin
                        best    = m;
                        best_at = i;
                    end
                end
                if (best_at == base + WINDOW / 2 && best > thr_now && base >= last_end)
                begin
                    if (seg_total < MAX_SEGMENTS)
                    begin
                        d.start_idx = INDEX_BITS'(base);
                        d.end_idx   = CNT_W'(base + WINDOW);
                        d.seg_no    = SEG_W'(seg_total);
                        d.done      = 1'b0;
                        d.seg_cnt   = '0;
                        d.dropped   = 1'b0;
                        d.last      = !rend;
                        detections_due.push_back(d);
                        last_end = base + WINDOW;
                        seg_total++;
                    end
                    else
                    begin
                        seg_over = 1'b1;
                    end
                end
            end
        end
        if (rend)
        begin
            d.start_idx = '0;
            d.end_idx   = '0;
            d.seg_no    = '0;
            d.done      = 1'b1;
            d.seg_cnt   = SEG_W'(seg_total);
            d.dropped   = seg_over;
            d.last      = 1'b1;
            detections_due.push_back(d);
            n_seen    = 0;
            last_end  = 0;
            seg_total = 0;
            seg_over  = 1'b0;
        end
    endtask

    task automatic check_field(string what, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // record_buf becomes one record, end flag on its final sample
    task automatic queue_record();
        sample_item_t it;
        int           i;
        for (i = 0; i < record_buf.size(); i++)
        begin
            it.value = record_buf[i];
            it.last  = (i == record_buf.size() - 1);
            samples_to_send.push_back(it);
        end
    endtask

    task automatic quiet_record(int len);
        int i;
        record_buf.delete();
        for (i = 0; i < len; i++)
        begin
            record_buf.push_back(with_sign(MAG_W'($urandom_range(0, 200)),
                                           1'($urandom_range(0, 1))));
        end
    endtask

    // one record: mostly a full window with a planted peak, some short or pure noise
    task automatic add_random_record(inout int windows_sent);
        int               len;
        int               tested;
        int               style;
        int               p;
        int               q;
        int               i;
        logic [MAG_W-1:0] bg;
        logic [MAG_W-1:0] pk;
        style = $urandom_range(0, 7);
        record_buf.delete();
        if (style == 0)
        begin
            // window never fills, summary only
            len = $urandom_range(1, 60);
            for (i = 0; i < len; i++)
            begin
                record_buf.push_back(SAMPLE_W'($urandom()));
            end
        end
        else
        begin
            tested = $urandom_range(1, 12);
            len    = WINDOW - 1 + tested;
            if ($urandom_range(0, 3) == 0)
            begin
                bg = MAG_W'($urandom_range(0, SAMPLE_MAX));
            end
            else
            begin
                bg = MAG_W'($urandom_range(0, 30000));
            end
            for (i = 0; i < len; i++)
            begin
                if (style == 1)
                begin
                    record_buf.push_back(SAMPLE_W'($urandom()));
                end
                else
                begin
                    record_buf.push_back(with_sign(MAG_W'($urandom_range(0, int'(bg))),
                                                   1'($urandom_range(0, 1))));
                end
            end
            if (style != 1)
            begin
                case ($urandom_range(0, 5))
                    0: pk = MOST_NEG_MAG;
                    1: pk = MAG_W'(thr_now);
                    2: pk = MAG_W'(thr_now) + 1'b1;
                    default: pk = MAG_W'($urandom_range(int'(bg) + 1, MAG_MOST));
                endcase
                p = WINDOW / 2 + $urandom_range(0, tested - 1);
                record_buf[p] = with_sign(pk, 1'($urandom_range(0, 1)));
                // equal magnitude later keeps the peak, earlier defeats it
                if ($urandom_range(0, 3) == 0)
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        q = p + $urandom_range(1, WINDOW / 2 - 1);
                    end
                    else
                    begin
                        q = p - $urandom_range(1, WINDOW / 2);
                    end
                    if (q < len)
                    begin
                        record_buf[q] = with_sign(pk, 1'($urandom_range(0, 1)));
                    end
                end
                // stray large value anywhere
                if ($urandom_range(0, 3) == 0)
                begin
                    record_buf[$urandom_range(0, len - 1)] =
                        with_sign(MAG_W'($urandom_range(0, MAG_MOST)),
                                  1'($urandom_range(0, 1)));
                end
            end
            windows_sent += tested;
        end
        queue_record();
    endtask

    task automatic random_records(int target);
        int sent;
        sent = 0;
        while (sent < target)
        begin
            add_random_record(sent);
        end
    endtask

    // all samples sent and all detections seen, then let the block settle
    task automatic wait_drained();
        while (samples_to_send.size() != 0 || in_valid || detections_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
        thr_now = v;
    endtask

    // sample driver, holds the payload until the transfer
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !sample_taken)
            begin
                // stalled, keep payload
            end
            else if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid   <= 1'b1;
                sample     <= samples_to_send[0].value;
                record_end <= samples_to_send[0].last;
                samples_to_send.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
            sample_taken = 1'b0;
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // result monitor and input transfer tracking
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (detections_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got start %0d end %0d done %0b",
                             $time, segment_start, segment_end, record_done);
                    mismatches++;
                end
                else
                begin
                    head = detections_due.pop_front();
                    check_field("segment_start", 64'(head.start_idx), 64'(segment_start));
                    check_field("segment_end", 64'(head.end_idx), 64'(segment_end));
                    check_field("segment_number", 64'(head.seg_no), 64'(segment_number));
                    check_field("record_done", 64'(head.done), 64'(record_done));
                    check_field("segment_count", 64'(head.seg_cnt), 64'(segment_count));
                    check_field("dropped_any", 64'(head.dropped), 64'(dropped_any));
                    check_field("last_of_run", 64'(head.last), 64'(last_of_run));
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_detections(sample, record_end);
                sample_taken = 1'b1;
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("** window_peak_segment_detector: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // record that ends on its first sample
        record_buf.delete();
        record_buf.push_back('0);
        queue_record();
        // short record with the sample extremes
        record_buf.delete();
        record_buf.push_back(SAMPLE_W'(SAMPLE_MAX));
        record_buf.push_back(with_sign(MOST_NEG_MAG, 1'b1));
        record_buf.push_back(-24'sd1);
        record_buf.push_back(24'sd1);
        record_buf.push_back(24'sd0);
        queue_record();
        // most negative sample peaks on the closing sample: segment then summary
        quiet_record(WINDOW);
        record_buf[WINDOW / 2] = with_sign(MOST_NEG_MAG, 1'b1);
        queue_record();
        // peak one sample later, tied by a later sample
        quiet_record(WINDOW + 2);
        record_buf[WINDOW / 2 + 1] = 24'sd20000;
        record_buf[WINDOW - 200]   = -24'sd20000;
        queue_record();
        // peak tied by an earlier sample
        quiet_record(WINDOW + 2);
        record_buf[WINDOW / 2] = 24'sd20000;
        record_buf[100]        = -24'sd20000;
        queue_record();
        // peak equal to the threshold, then just above it
        quiet_record(WINDOW);
        record_buf[WINDOW / 2] = SAMPLE_W'(int'(THR_RESET));
        queue_record();
        quiet_record(WINDOW);
        record_buf[WINDOW / 2] = -SAMPLE_W'(int'(THR_RESET) + 1);
        queue_record();

        random_records(WINDOWS_PER_PH);
        wait_drained();

        // zero threshold, sender idles
        write_threshold('0);
        send_idle_pct = 48;
        random_records(WINDOWS_PER_PH);
        wait_drained();

        // top threshold, only the most negative sample can pass; receiver stalls
        write_threshold({THR_W{1'b1}});
        send_idle_pct = 0;
        stall_pct     = 48;
        random_records(WINDOWS_PER_PH);
        wait_drained();

        // random threshold, both sides idle
        write_threshold(THR_W'($urandom_range(1, 200000)));
        send_idle_pct = 18;
        stall_pct     = 18;
        random_records(WINDOWS_PER_PH);
        wait_drained();

        if (mismatches == 0)
        begin
            $display("** window_peak_segment_detector: PASSED **");
        end
        else
        begin
            $display("** window_peak_segment_detector: FAILED **");
        end
        $finish;
    end

endmodule

FILE: window_peak_segment_detector.f
+incdir+hdl
hdl/wpsd_pkg.sv
hdl/wpsd_ram.sv
hdl/wpsd_peak_unit.sv
hdl/window_peak_segment_detector.sv
test/testbench.sv
